>>> hw/rtl/task_priority_table_unit_assert.svh
// assertion macros for the task priority table unit
// used by task_priority_table_unit.sv, needs i_clk and i_rst_n in scope
`ifndef TASK_PRIORITY_TABLE_UNIT_ASSERT_SVH
`define TASK_PRIORITY_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is held
`define TPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is held
`define TPT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tpt_pkg.sv
// shared types and codes for the task priority table unit
// no dependencies
`timescale 1ns / 1ps

package tpt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_EDIT   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_EXEC   = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // one table slot as stored in the ram
    typedef struct packed {
        logic        valid;
        logic [15:0] task_id;
        logic [15:0] user_id;
        logic [31:0] prio;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

endpackage

>>> hw/rtl/tpt_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/task_priority_table_unit.sv
// task priority table: indexed max-priority queue kept in one ram, scanned per command
// depends on tpt_pkg, tpt_ram and task_priority_table_unit_assert.svh
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_command i_user_id i_task_id i_priority_req
//   out     | output    | o_out_valid / i_out_stall | o_found o_user_id_out o_status
//
// each command is accepted, then every slot is read in turn through the single ram read port,
// whose read is registered, and the command ends with its write back, if any, and its result word
// after reset the ram is cleared one slot a cycle, with o_in_stall high
// a result waits in the output register; the next command may be accepted and scanned
// meanwhile, its write back holds until the waiting word is taken
`timescale 1ns / 1ps

`include "task_priority_table_unit_assert.svh"

module task_priority_table_unit
    import tpt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_user_id,
    input  logic [15:0] i_task_id,
    input  logic [31:0] i_priority_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found,
    output logic [15:0] o_user_id_out,
    output logic [1:0]  o_status
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] END_CNT  = CW'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state      r_state;
    logic [CW-1:0] r_cnt;

    // latched command
    t_cmd        r_cmd;
    logic [15:0] r_user;
    logic [15:0] r_task;
    logic [31:0] r_prio;

    // read pipeline
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;

    // scan results
    logic          r_match_hit;
    logic [AW-1:0] r_match_idx;
    logic [15:0]   r_match_user;
    logic          r_free_hit;
    logic [AW-1:0] r_free_idx;
    logic          r_best_hit;
    logic [AW-1:0] r_best_idx;
    logic [31:0]   r_best_prio;
    logic [15:0]   r_best_task;
    logic [15:0]   r_best_user;

    // output register
    logic        r_out_valid;
    logic        r_found;
    logic [15:0] r_user_out;
    logic [1:0]  r_status;

    t_entry        rd_entry;
    logic [ENTRY_BITS-1:0] rd_bits;
    t_entry        wr_entry;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_issue;
    logic          out_free;
    logic          finish_go;
    logic          in_accept;
    logic          is_match;
    logic          is_better;

    // per-command write back and result
    logic        fin_we;
    logic [AW-1:0] fin_addr;
    t_entry      fin_entry;
    logic        fin_found;
    logic [15:0] fin_user;
    logic [1:0]  fin_status;

    tpt_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd_bits)
    );

    assign rd_entry  = t_entry'(rd_bits);
    assign rd_issue  = (r_state == S_SCAN) && (r_cnt != END_CNT);
    assign rd_addr   = r_cnt[AW-1:0];
    assign out_free  = !r_out_valid || !i_out_stall;
    assign finish_go = (r_state == S_FINISH) && out_free;
    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    assign is_match  = rd_entry.valid && (rd_entry.task_id == r_task);
    assign is_better = !r_best_hit
                    || (rd_entry.prio > r_best_prio)
                    || ((rd_entry.prio == r_best_prio) && (rd_entry.task_id > r_best_task));

    always_comb begin
        fin_we            = 1'b0;
        fin_addr          = r_match_idx;
        fin_entry.valid   = 1'b1;
        fin_entry.task_id = r_task;
        fin_entry.user_id = r_user;
        fin_entry.prio    = r_prio;
        fin_found         = 1'b0;
        fin_user          = 16'd0;
        fin_status        = ST_OK;
        case (r_cmd)
            CMD_ADD: begin
                if (r_match_hit) begin
                    fin_we = 1'b1;
                end else if (r_free_hit) begin
                    fin_we   = 1'b1;
                    fin_addr = r_free_idx;
                end else begin
                    fin_status = ST_FULL;
                end
            end
            CMD_EDIT: begin
                fin_entry.user_id = r_match_user;
                if (r_match_hit) begin
                    fin_we = 1'b1;
                end else begin
                    fin_status = ST_ABSENT;
                end
            end
            CMD_REMOVE: begin
                fin_entry.valid = 1'b0;
                if (r_match_hit) begin
                    fin_we = 1'b1;
                end else begin
                    fin_status = ST_ABSENT;
                end
            end
            CMD_EXEC: begin
                fin_entry.valid = 1'b0;
                fin_addr        = r_best_idx;
                if (r_best_hit) begin
                    fin_we    = 1'b1;
                    fin_found = 1'b1;
                    fin_user  = r_best_user;
                end else begin
                    fin_status = ST_EMPTY;
                end
            end
            default: begin
                fin_we = 1'b0;
            end
        endcase
    end

    // clearing pass writes empty slots, otherwise the write back of a finished command
    always_comb begin
        if (r_state == S_CLEAR) begin
            wr_en    = 1'b1;
            wr_addr  = r_cnt[AW-1:0];
            wr_entry = '0;
        end else begin
            wr_en    = finish_go && fin_we;
            wr_addr  = fin_addr;
            wr_entry = fin_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !finish_go) begin
                r_out_valid <= 1'b0;
            end
            r_rd_vld <= rd_issue;
            r_rd_idx <= rd_addr;
            case (r_state)
                S_CLEAR: begin
                    if (r_cnt[AW-1:0] == LAST_IDX) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd       <= t_cmd'(i_command);
                        r_user      <= i_user_id;
                        r_task      <= i_task_id;
                        r_prio      <= i_priority_req;
                        r_cnt       <= '0;
                        r_match_hit <= 1'b0;
                        r_free_hit  <= 1'b0;
                        r_best_hit  <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rd_issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_rd_vld) begin
                        if (is_match) begin
                            r_match_hit  <= 1'b1;
                            r_match_idx  <= r_rd_idx;
                            r_match_user <= rd_entry.user_id;
                        end
                        // scan is in ascending order, so the first free slot is the lowest
                        if (!rd_entry.valid && !r_free_hit) begin
                            r_free_hit <= 1'b1;
                            r_free_idx <= r_rd_idx;
                        end
                        if (rd_entry.valid && is_better) begin
                            r_best_hit  <= 1'b1;
                            r_best_idx  <= r_rd_idx;
                            r_best_prio <= rd_entry.prio;
                            r_best_task <= rd_entry.task_id;
                            r_best_user <= rd_entry.user_id;
                        end
                        if (r_rd_idx == LAST_IDX) begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_found     <= fin_found;
                        r_user_out  <= fin_user;
                        r_status    <= fin_status;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_user_id_out = r_user_out;
    assign o_status      = r_status;

    `TPT_ASSERT_IMP(a_found_ok, o_out_valid && o_found, o_status == ST_OK, "found word without ok status")
    `TPT_ASSERT_IMP(a_no_user, o_out_valid && !o_found, o_user_id_out == 16'd0, "user set on a word without a task")
    `TPT_ASSERT_NXT(a_out_drain, o_out_valid && !i_out_stall && r_state != S_FINISH, !o_out_valid, "taken word shown again")
    `TPT_ASSERT_IMP(a_read_in_scan, r_rd_vld, r_state == S_SCAN, "read data returned outside the scan")

endmodule

>>> bench/testbench.sv
// self-checking bench for task_priority_table_unit: directed and random command words
// checked against a table model kept here; needs tpt_pkg and the unit's rtl
`timescale 1ns / 1ps

module testbench;
    import tpt_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int RANDOM_WORDS  = 550;
    localparam int HOLD_CYCLES   = 1500;
    localparam int DRAIN_CYCLES  = TABLE_ENTRIES + 8;
    localparam int MAX_CYCLES    = 2_000_000;

    typedef struct packed {
        logic        found;
        logic [15:0] user_id;
        logic [1:0]  status;
    } t_outcome;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [1:0]  i_command      = CMD_ADD;
    logic [15:0] i_user_id      = '0;
    logic [15:0] i_task_id      = '0;
    logic [31:0] i_priority_req = '0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_found;
    logic [15:0] o_user_id_out;
    logic [1:0]  o_status;

    // table image kept in step with every accepted word
    logic        tbl_valid [TABLE_ENTRIES];
    logic [15:0] tbl_task  [TABLE_ENTRIES];
    logic [15:0] tbl_user  [TABLE_ENTRIES];
    logic [31:0] tbl_prio  [TABLE_ENTRIES];

    t_outcome expected_outcomes[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       src_idle_pct   = 0;
    int       sink_idle_pct  = 0;
    logic     sink_hold      = 1'b0;
    logic     table_filling  = 1'b1;

    task_priority_table_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_user_id      (i_user_id),
        .i_task_id      (i_task_id),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_user_id_out  (o_user_id_out),
        .o_status       (o_status)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("task_priority_table_unit test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= sink_hold || ($urandom_range(0, 99) < sink_idle_pct);
    end

    function automatic t_outcome apply_command(t_cmd cmd, logic [15:0] uid,
                                               logic [15:0] tid, logic [31:0] prio);
        t_outcome res;
        int       hit;
        int       slot;
        int       best;
        res  = '{found: 1'b0, user_id: 16'h0, status: ST_OK};
        hit  = -1;
        slot = -1;
        best = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_task[i] == tid && hit < 0) hit = i;
            if (!tbl_valid[i] && slot < 0) slot = i;
        end
        case (cmd)
            CMD_ADD: begin
                if (hit >= 0) slot = hit;
                if (slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    tbl_valid[slot] = 1'b1;
                    tbl_task[slot]  = tid;
                    tbl_user[slot]  = uid;
                    tbl_prio[slot]  = prio;
                end
            end
            CMD_EDIT: begin
                if (hit < 0) res.status = ST_ABSENT;
                else tbl_prio[hit] = prio;
            end
            CMD_REMOVE: begin
                if (hit < 0) res.status = ST_ABSENT;
                else tbl_valid[hit] = 1'b0;
            end
            default: begin
                // highest priority wins, equal priorities go to the larger id
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (tbl_valid[i] && (best < 0 || tbl_prio[i] > tbl_prio[best] ||
                        (tbl_prio[i] == tbl_prio[best] && tbl_task[i] > tbl_task[best])))
                        best = i;
                end
                if (best < 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.found   = 1'b1;
                    res.user_id = tbl_user[best];
                    tbl_valid[best] = 1'b0;
                end
            end
        endcase
        return res;
    endfunction

    function automatic int count_used();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) if (tbl_valid[i]) n++;
        return n;
    endfunction

    function automatic logic [15:0] stored_id();
        int slots[$];
        for (int i = 0; i < TABLE_ENTRIES; i++) if (tbl_valid[i]) slots.push_back(i);
        return tbl_task[slots[$urandom_range(0, slots.size() - 1)]];
    endfunction

    task automatic report_field(string name, logic [31:0] expv, logic [31:0] actv);
        if (expv !== actv) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expv, actv);
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_outcomes.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none actual found=%0h user=%0h status=%0h",
                         $time, o_found, o_user_id_out, o_status);
            end else begin
                want = expected_outcomes.pop_front();
                report_field("found", 32'(want.found), 32'(o_found));
                report_field("user_id_out", 32'(want.user_id), 32'(o_user_id_out));
                report_field("status", 32'(want.status), 32'(o_status));
            end
        end
    end

    // offers one word, holds it until taken, then records what it should produce
    task automatic send_word(t_cmd cmd, logic [15:0] uid, logic [15:0] tid,
                             logic [31:0] prio);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2 * TABLE_ENTRIES + 12)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_user_id      <= uid;
        i_task_id      <= tid;
        i_priority_req <= prio;
        do @(posedge i_clk); while (o_in_stall);
        expected_outcomes.push_back(apply_command(cmd, uid, tid, prio));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic random_word();
        int          used;
        int          r;
        t_cmd        cmd;
        logic [15:0] uid;
        logic [15:0] tid;
        logic [31:0] prio;
        used = count_used();
        if (used == 0) table_filling = 1'b1;
        else if (used == TABLE_ENTRIES && $urandom_range(0, 9) == 0) table_filling = 1'b0;
        r = $urandom_range(0, 99);
        if (table_filling)
            cmd = r < 60 ? CMD_ADD : r < 75 ? CMD_EDIT : r < 85 ? CMD_REMOVE : CMD_EXEC;
        else
            cmd = r < 15 ? CMD_ADD : r < 35 ? CMD_EDIT : r < 55 ? CMD_REMOVE : CMD_EXEC;
        uid = 16'($urandom);
        // stored ids for most edits, removes and execs but a quarter of adds; half the fresh ids cluster at both ends
        if (used > 0 && $urandom_range(0, 99) < (cmd == CMD_ADD ? 25 : 75))
            tid = stored_id();
        else if ($urandom_range(0, 1))
            tid = 16'($urandom);
        else
            tid = {($urandom_range(0, 1) ? 12'hFFF : 12'h000), 4'($urandom)};
        if ($urandom_range(0, 99) < 30) begin
            case ($urandom_range(0, 5))
                0: prio = 32'h0;
                1: prio = 32'h1;
                2: prio = 32'h2;
                3: prio = 32'h7FFF_FFFF;
                4: prio = 32'h8000_0000;
                default: prio = 32'hFFFF_FFFF;
            endcase
        end else begin
            prio = $urandom;
        end
        send_word(cmd, uid, tid, prio);
    endtask

    task automatic test_directed_cases();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_word(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);          // empty table
        send_word(CMD_EDIT,   16'h0000, 16'h1234, 32'h5);          // absent id
        send_word(CMD_REMOVE, 16'h0000, 16'h1234, 32'h0);
        send_word(CMD_ADD,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(CMD_ADD,    16'h0000, 16'h0000, 32'h0);
        send_word(CMD_ADD,    16'h1111, 16'h0005, 32'h7);
        send_word(CMD_ADD,    16'h2222, 16'h0009, 32'h7);
        send_word(CMD_ADD,    16'h3333, 16'h0005, 32'h7);          // overwrite in place
        send_word(CMD_EDIT,   16'h0000, 16'h0000, 32'h8000_0000);
        send_word(CMD_ADD,    16'h5555, 16'h8000, 32'h8000_0000);
        send_word(CMD_ADD,    16'h6666, 16'h0007, 32'h7FFF_FFFF);  // unsigned compare
        send_word(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);
        send_word(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);
        send_word(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);
        send_word(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);
        send_word(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);          // equal priority tie
        send_word(CMD_REMOVE, 16'h0000, 16'h0005, 32'h0);
        send_word(CMD_REMOVE, 16'h0000, 16'h0005, 32'h0);
        send_word(CMD_ADD,    16'h0F0F, 16'h0003, 32'h0);
        send_word(CMD_ADD,    16'hF0F0, 16'h0004, 32'h1);
        send_word(CMD_REMOVE, 16'h0000, 16'h0004, 32'h0);
        send_word(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);
        send_word(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);
        wait_for_results();
    endtask

    task automatic test_random_mix(int src_pct, int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (RANDOM_WORDS) random_word();
        wait_for_results();
    endtask

    // output held off long enough for the unit to fill and stall its input
    task automatic test_output_hold_off();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
        join_none
        repeat (40) random_word();
        wait_for_results();
    endtask

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_task[i]  = '0;
            tbl_user[i]  = '0;
            tbl_prio[i]  = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_random_mix(18, 82);
        test_output_hold_off();
        test_random_mix(82, 18);
        test_random_mix(0, 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
            $display("task_priority_table_unit test passed");
        end else begin
            $display("task_priority_table_unit test failed");
        end
        $finish;
    end

endmodule
